// ===== hdl/ebur_pkg.sv =====
// Package for the edit buffer with undo and redo: request and result beats,
// request and status codes, and the controller/datapath command and status structs.
// Depends on nothing.
package ebur_pkg;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_UNDO   = 3'd2;
  localparam logic [2:0] REQ_REDO   = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // Status codes returned with every result.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_POS   = 3'd1;
  localparam logic [2:0] ST_NO_UNDO   = 3'd2;
  localparam logic [2:0] ST_NO_REDO   = 3'd3;
  localparam logic [2:0] ST_BUF_FULL  = 3'd4;

  // Kind of a history record.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // One request beat.
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_in;
    logic [6:0] position;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [2:0] status;
    logic [6:0] text_length;
    logic [7:0] char_out;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic fetch;
    logic shift;
    logic finish;
    logic emit;
  } ebur_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;
    logic is_read;
    logic fit;
    logic shift_busy;
  } ebur_stat_t;

endpackage

// ===== hdl/ebur_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ebur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ebur_ctrl.sv =====
// Controller state machine of the edit buffer: sequences check, fetch, shift,
// finish and result phases. Depends on ebur_pkg.
module ebur_ctrl
  import ebur_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output ebur_cmd_t  cmd,
  input  ebur_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_SHIFT,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // Commands follow the state; load fires on an accepted request beat.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.go ? S_FETCH : S_EMIT;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (stat.is_read || !stat.fit) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (!stat.shift_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and the registered result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EMIT);
    end
  end

  // The result strobe comes only once the machine is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while busy");

  // An accepted request always starts with the check phase.
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CHECK))
    else $error("accepted request did not enter check");

  // Every request ends in exactly one result beat.
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> done)
    else $error("emit phase without result strobe");

endmodule

// ===== hdl/ebur_dp.sv =====
// Datapath of the edit buffer: text RAM, undo ring and redo stack RAMs,
// counters, character shift engine and result register. Depends on ebur_pkg, ebur_ram.
module ebur_dp
  import ebur_pkg::*;
#(
  parameter int BUF_DEPTH  = 64,
  parameter int HIST_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  ebur_cmd_t  cmd,
  output ebur_stat_t stat,
  output res_t       result
);

  localparam int AW  = $clog2(BUF_DEPTH);
  localparam int CW  = $clog2(BUF_DEPTH + 1);
  localparam int MW  = (CW > 7) ? CW : 7;
  localparam int HW  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HCW = $clog2(HIST_DEPTH + 1);
  localparam int RW  = 1 + 8 + AW;

  typedef struct packed {
    logic          kind;
    logic [7:0]    ch;
    logic [AW-1:0] pos;
  } rec_t;

  // Request and working registers.
  req_t            req_q;
  logic [2:0]      status_q;
  logic [7:0]      char_out_q;
  rec_t            rec;
  logic            text_ins;
  logic [CW-1:0]   count;
  logic [HW-1:0]   undo_top;
  logic [HCW-1:0]  undo_count;
  logic [HCW-1:0]  redo_count;
  logic [AW-1:0]   rd_idx;
  logic [AW-1:0]   wr_idx;
  logic            wr_pend;
  logic [CW-1:0]   moves;

  // RAM ports.
  logic            text_we;
  logic [AW-1:0]   text_waddr;
  logic [7:0]      text_wdata;
  logic [AW-1:0]   text_raddr;
  logic [7:0]      text_rdata;
  logic            undo_we;
  logic [RW-1:0]   undo_rdata;
  logic [HW-1:0]   undo_raddr;
  logic            redo_we;
  logic [RW-1:0]   redo_rdata;
  logic [HW-1:0]   redo_raddr;

  // Combinational helpers.
  logic [MW-1:0]   pos_ext;
  logic [MW-1:0]   cnt_ext;
  logic [AW-1:0]   pos_a;
  logic [2:0]      status_next;
  rec_t            rec_next;
  logic            ins_next;
  logic            fit_next;
  logic [HW-1:0]   top_inc;
  logic [HW-1:0]   top_dec;
  logic [HCW-1:0]  redo_dec;
  logic            undo_full;
  logic            redo_full;
  logic            is_edit;

  assign pos_ext   = MW'(req_q.position);
  assign cnt_ext   = MW'(count);
  assign pos_a     = AW'(req_q.position);
  assign top_inc   = (undo_top == HW'(HIST_DEPTH - 1)) ? '0 : undo_top + 1'b1;
  assign top_dec   = (undo_top == '0) ? HW'(HIST_DEPTH - 1) : undo_top - 1'b1;
  assign redo_dec  = redo_count - 1'b1;
  assign undo_full = (undo_count == HCW'(HIST_DEPTH));
  assign redo_full = (redo_count == HCW'(HIST_DEPTH));
  assign is_edit   = (req_q.req_type == REQ_INSERT) || (req_q.req_type == REQ_DELETE);

  // Request checks against the current buffer and history fill.
  always_comb begin
    status_next = ST_OK;
    case (req_q.req_type)
      REQ_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_next = ST_BAD_POS;
        end else if (count == CW'(BUF_DEPTH)) begin
          status_next = ST_BUF_FULL;
        end
      end
      REQ_DELETE, REQ_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_next = ST_BAD_POS;
        end
      end
      REQ_UNDO: begin
        if (undo_count == '0) begin
          status_next = ST_NO_UNDO;
        end
      end
      REQ_REDO: begin
        if (redo_count == '0) begin
          status_next = ST_NO_REDO;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // The edit record for this request, from the request or from a history.
  always_comb begin
    rec_next.kind = KIND_INSERT;
    rec_next.ch   = req_q.char_in;
    rec_next.pos  = pos_a;
    case (req_q.req_type)
      REQ_DELETE: begin
        rec_next.kind = KIND_DELETE;
        rec_next.ch   = text_rdata;
      end
      REQ_UNDO: begin
        rec_next = rec_t'(undo_rdata);
      end
      REQ_REDO: begin
        rec_next = rec_t'(redo_rdata);
      end
      default: begin
        rec_next.kind = KIND_INSERT;
      end
    endcase
  end

  // Undo reverses the record; the shift is skipped when it does not fit.
  assign ins_next = (rec_next.kind == KIND_INSERT) ^ (req_q.req_type == REQ_UNDO);
  assign fit_next = ins_next ?
                    ((CW'(rec_next.pos) <= count) && (count < CW'(BUF_DEPTH))) :
                    (CW'(rec_next.pos) < count);

  assign stat.go         = (status_next == ST_OK) && (req_q.req_type <= REQ_READ);
  assign stat.is_read    = (req_q.req_type == REQ_READ);
  assign stat.fit        = fit_next;
  assign stat.shift_busy = (moves != '0) || wr_pend;

  // Text RAM ports: position lookup during check, shift reads after that.
  assign text_raddr = cmd.check ? pos_a : rd_idx;
  assign text_we    = wr_pend || (cmd.finish && text_ins);
  assign text_waddr = wr_pend ? wr_idx : rec.pos;
  assign text_wdata = wr_pend ? text_rdata : rec.ch;

  // History RAM ports: read the tops in check, push in fetch.
  assign undo_raddr = top_dec;
  assign redo_raddr = redo_dec[HW-1:0];
  assign undo_we    = cmd.fetch && (is_edit || (req_q.req_type == REQ_REDO));
  assign redo_we    = cmd.fetch && (req_q.req_type == REQ_UNDO) && !redo_full;

  ebur_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_waddr),
    .wdata (text_wdata),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  ebur_ram #(.WIDTH(RW), .DEPTH(HIST_DEPTH)) u_undo_ram (
    .clk   (clk),
    .we    (undo_we),
    .waddr (undo_top),
    .wdata (RW'(rec_next)),
    .raddr (undo_raddr),
    .rdata (undo_rdata)
  );

  ebur_ram #(.WIDTH(RW), .DEPTH(HIST_DEPTH)) u_redo_ram (
    .clk   (clk),
    .we    (redo_we),
    .waddr (redo_count[HW-1:0]),
    .wdata (RW'(rec_next)),
    .raddr (redo_raddr),
    .rdata (redo_rdata)
  );

  // Counters and history pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      undo_top   <= '0;
      undo_count <= '0;
      redo_count <= '0;
      moves      <= '0;
      wr_pend    <= 1'b0;
    end else begin
      if (cmd.fetch) begin
        case (req_q.req_type)
          REQ_INSERT, REQ_DELETE: begin
            undo_top   <= top_inc;
            undo_count <= undo_full ? undo_count : undo_count + 1'b1;
            redo_count <= '0;
          end
          REQ_UNDO: begin
            undo_top   <= top_dec;
            undo_count <= undo_count - 1'b1;
            redo_count <= redo_full ? redo_count : redo_count + 1'b1;
          end
          REQ_REDO: begin
            redo_count <= redo_dec;
            undo_top   <= top_inc;
            undo_count <= undo_full ? undo_count : undo_count + 1'b1;
          end
          default: begin
            undo_top <= undo_top;
          end
        endcase
        // Characters that move: those from the position to the end on insert, those after it on delete.
        if (ins_next) begin
          moves <= count - CW'(rec_next.pos);
        end else begin
          moves <= count - CW'(rec_next.pos) - 1'b1;
        end
        wr_pend <= 1'b0;
      end else if (cmd.shift) begin
        wr_pend <= (moves != '0);
        if (moves != '0) begin
          moves <= moves - 1'b1;
        end
      end
      if (cmd.finish) begin
        count <= text_ins ? count + 1'b1 : count - 1'b1;
      end
    end
  end

  // Request, record, shift indexes and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q      <= req;
      char_out_q <= '0;
    end
    if (cmd.check) begin
      status_q <= status_next;
    end
    if (cmd.fetch) begin
      rec      <= rec_next;
      text_ins <= ins_next;
      if (stat.is_read) begin
        char_out_q <= text_rdata;
      end
      if (ins_next) begin
        rd_idx <= AW'(count - 1'b1);
      end else begin
        rd_idx <= rec_next.pos + 1'b1;
      end
    end else if (cmd.shift && (moves != '0)) begin
      // Insert walks down and moves up by one; delete walks up and moves down.
      wr_idx <= text_ins ? rd_idx + 1'b1 : rd_idx - 1'b1;
      rd_idx <= text_ins ? rd_idx - 1'b1 : rd_idx + 1'b1;
    end
    if (cmd.emit) begin
      result.status      <= status_q;
      result.text_length <= 7'(count);
      result.char_out    <= char_out_q;
    end
  end

  // The buffer never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(BUF_DEPTH))
    else $error("text count beyond buffer depth");

  // A fresh edit forgets the redo history.
  a_redo_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.fetch && is_edit) |=> (redo_count == '0))
    else $error("redo history survived a fresh edit");

  // The final insert write never collides with a pending shift write.
  a_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_pend && cmd.finish))
    else $error("shift write and final write in one cycle");

endmodule

// ===== hdl/edit_buffer_undo_redo.sv =====
// Top level of the edit buffer with undo and redo.
// Depends on ebur_pkg, ebur_ctrl, ebur_dp (and ebur_ram through ebur_dp).
//
// One request at a time: a beat is taken when start is high and busy is low,
// and exactly one result beat follows on result, marked by done for one cycle;
// the receiver cannot stall it and must take it then. A rejected request
// passes through check and then emit, a read through check, fetch and emit,
// and an insert, delete, undo or redo through check, fetch, shift, finish
// and emit, where the shift phase moves n characters one place (up to
// BUF_DEPTH - 1). The shift engine moves one character per cycle through
// the single write port of the text RAM. A new request may be started in
// the cycle that done is high. Text and history RAMs need no clearing
// after reset.
module edit_buffer_undo_redo
  import ebur_pkg::*;
#(
  parameter int BUF_DEPTH  = 64,
  parameter int HIST_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t result
);

  ebur_cmd_t  cmd;
  ebur_stat_t stat;

  // Sequencing.
  ebur_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Storage and arithmetic.
  ebur_dp #(
    .BUF_DEPTH  (BUF_DEPTH),
    .HIST_DEPTH (HIST_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for edit_buffer_undo_redo: directed edge cases, then random edit sessions.
// A shadow of the buffer and both histories predicts every result beat.
// Depends on ebur_pkg and the edit_buffer_undo_redo RTL.
module tb;
  import ebur_pkg::*;

  localparam int DEPTH = 64;
  localparam int HIST = 32;
  localparam int RANDOM_ITEMS = 1800;
  localparam int SETTLE = 80;
  localparam int LIMIT = 1000000;

  // Request codes the block does not decode.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  // One history record as the shadow keeps it.
  typedef struct packed {
    logic kind;
    logic [7:0] ch;
    logic [6:0] pos;
  } edit_rec_t;

  // Shadow of the edit buffer and its histories, with the results still owed by the block.
  class edit_shadow;
    logic [7:0] text [DEPTH];
    int count;
    edit_rec_t undo_ring [HIST];
    int undo_top;
    int undo_count;
    edit_rec_t redo_stack [HIST];
    int redo_count;
    res_t awaited [$];
    int errors;

    function new();
      count = 0;
      undo_top = 0;
      undo_count = 0;
      redo_count = 0;
      errors = 0;
    endfunction

    // Open a slot at pos and place ch there.
    function bit put_char(int pos, logic [7:0] ch);
      if (pos > count || count >= DEPTH) return 1'b0;
      for (int i = count; i > pos; i--) text[i] = text[i - 1];
      text[pos] = ch;
      count++;
      return 1'b1;
    endfunction

    // Close the slot at pos.
    function bit drop_char(int pos);
      if (pos >= count) return 1'b0;
      for (int i = pos; i + 1 < count; i++) text[i] = text[i + 1];
      count--;
      return 1'b1;
    endfunction

    // The undo ring drops its oldest record when it is full.
    function void push_undo(edit_rec_t e);
      undo_ring[undo_top] = e;
      undo_top = (undo_top + 1) % HIST;
      if (undo_count < HIST) undo_count++;
    endfunction

    // Apply one accepted request beat and queue the result it must produce.
    function void note_request(req_t r);
      res_t res;
      edit_rec_t e;
      int pos;
      pos = int'(r.position);
      res = '0;
      res.status = ST_OK;
      case (r.req_type)
        REQ_INSERT: begin
          if (pos > count) begin
            res.status = ST_BAD_POS;
          end else if (count >= DEPTH) begin
            res.status = ST_BUF_FULL;
          end else begin
            void'(put_char(pos, r.char_in));
            e.kind = KIND_INSERT;
            e.ch = r.char_in;
            e.pos = r.position;
            push_undo(e);
            redo_count = 0;
          end
        end
        REQ_DELETE: begin
          if (pos >= count) begin
            res.status = ST_BAD_POS;
          end else begin
            e.kind = KIND_DELETE;
            e.ch = text[pos];
            e.pos = r.position;
            void'(drop_char(pos));
            push_undo(e);
            redo_count = 0;
          end
        end
        REQ_UNDO: begin
          if (undo_count == 0) begin
            res.status = ST_NO_UNDO;
          end else begin
            undo_top = (undo_top + HIST - 1) % HIST;
            undo_count--;
            e = undo_ring[undo_top];
            if (redo_count < HIST) begin
              redo_stack[redo_count] = e;
              redo_count++;
            end
            if (e.kind == KIND_INSERT) void'(drop_char(int'(e.pos)));
            else void'(put_char(int'(e.pos), e.ch));
          end
        end
        REQ_REDO: begin
          if (redo_count == 0) begin
            res.status = ST_NO_REDO;
          end else begin
            redo_count--;
            e = redo_stack[redo_count];
            push_undo(e);
            if (e.kind == KIND_INSERT) void'(put_char(int'(e.pos), e.ch));
            else void'(drop_char(int'(e.pos)));
          end
        end
        REQ_READ: begin
          if (pos >= count) res.status = ST_BAD_POS;
          else res.char_out = text[pos];
        end
        default: begin
          // Unused codes leave everything as it is.
        end
      endcase
      res.text_length = 7'(count);
      awaited.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Match a result beat against the oldest outstanding prediction.
    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = awaited.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("text_length", want.text_length, got.text_length);
      compare_field("char_out", want.char_out, got.char_out);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t result;

  edit_shadow shadow = new();
  int issued = 0;
  int cycles = 0;
  bit steady = 1'b0;

  edit_buffer_undo_redo #(
    .BUF_DEPTH (DEPTH),
    .HIST_DEPTH(HIST)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .result(result)
  );

  always #4 clk = ~clk;

  // Every result beat is checked in the cycle it appears.
  always @(posedge clk) begin
    if (!rst && done) shadow.check_result(result);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Idle time between request beats: mostly none or short, now and then long.
  function int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Insert position: mostly in range, with the ends and some bad positions.
  function int insert_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return shadow.count;
    if (r == 2) return $urandom_range(shadow.count + 1, 127);
    return $urandom_range(0, shadow.count);
  endfunction

  // Delete or read position: mostly an existing character.
  function int char_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return (shadow.count > 0) ? shadow.count - 1 : 0;
    if (r == 2) return $urandom_range(shadow.count, 127);
    if (shadow.count == 0) return $urandom_range(0, 127);
    return $urandom_range(0, shadow.count - 1);
  endfunction

  // Present one request beat, hold it until taken, then idle for a random gap, which may be none.
  task automatic send(logic [2:0] kind, logic [7:0] ch, int pos);
    req_t r;
    int gap;
    r.req_type = kind;
    r.char_in = ch;
    r.position = 7'(pos);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    shadow.note_request(r);
    if (kind <= REQ_READ) issued++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic quiet();
    start <= 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One random request with realistic weights.
  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) send(REQ_INSERT, 8'($urandom), insert_pos());
    else if (r < 55) send(REQ_DELETE, 8'($urandom), char_pos());
    else if (r < 70) send(REQ_UNDO, 8'($urandom), $urandom_range(0, 127));
    else if (r < 82) send(REQ_REDO, 8'($urandom), $urandom_range(0, 127));
    else if (r < 97) send(REQ_READ, 8'($urandom), char_pos());
    else send(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), 8'($urandom),
              $urandom_range(0, 127));
  endtask

  // Edge cases on a short buffer: empty histories, bad positions, extremes, unused codes.
  task automatic directed();
    send(REQ_UNDO, 8'h00, 0);
    send(REQ_REDO, 8'h00, 0);
    send(REQ_READ, 8'h00, 0);
    send(REQ_DELETE, 8'h00, 0);
    send(REQ_INSERT, 8'h11, 1);
    send(REQ_INSERT, 8'hFF, 127);
    send(REQ_INSERT, 8'h00, 0);
    send(REQ_INSERT, 8'hFF, 1);
    send(REQ_INSERT, 8'h80, 0);
    send(REQ_READ, 8'hFF, 0);
    send(REQ_READ, 8'h00, 2);
    send(REQ_READ, 8'h00, 3);
    send(REQ_READ, 8'h00, 127);
    send(REQ_DELETE, 8'h00, 1);
    send(REQ_DELETE, 8'h00, 127);
    send(REQ_UNDO, 8'h00, 0);
    send(REQ_UNDO, 8'h00, 0);
    send(REQ_REDO, 8'h00, 0);
    send(REQ_INSERT, 8'h7F, 1);
    send(REQ_REDO, 8'h00, 0);
    send(REQ_UNUSED_LO, 8'hFF, 127);
    send(3'd6, 8'h55, 42);
    send(REQ_UNUSED_HI, 8'h00, 0);
    send(REQ_READ, 8'h00, 1);
  endtask

  // Random sessions until enough requests have been accepted.
  task automatic random_phase();
    int goal;
    int n;
    goal = issued + RANDOM_ITEMS;
    while (issued < goal) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(5, 40);
          repeat (n) random_request();
        end
        4: begin
          // Fill to the brim, then knock on the full buffer.
          while (shadow.count < DEPTH)
            send(REQ_INSERT, 8'($urandom), $urandom_range(0, shadow.count));
          send(REQ_INSERT, 8'($urandom), shadow.count);
          send(REQ_INSERT, 8'($urandom), $urandom_range(shadow.count + 1, 127));
          send(REQ_INSERT, 8'($urandom), 0);
          send(REQ_READ, 8'h00, DEPTH - 1);
          send(REQ_READ, 8'h00, DEPTH);
        end
        5: begin
          // Empty the buffer one character at a time.
          while (shadow.count > 0)
            send(REQ_DELETE, 8'($urandom), $urandom_range(0, shadow.count - 1));
          send(REQ_DELETE, 8'($urandom), 0);
        end
        6: begin
          n = $urandom_range(1, 40);
          repeat (n) send(REQ_UNDO, 8'($urandom), $urandom_range(0, 127));
          n = $urandom_range(1, 40);
          repeat (n) send(REQ_REDO, 8'($urandom), $urandom_range(0, 127));
        end
        7: begin
          // Overflow the undo ring, then walk it back and forward past both ends.
          repeat (HIST + 4) begin
            if (shadow.count < DEPTH && (shadow.count == 0 || $urandom_range(0, 1)))
              send(REQ_INSERT, 8'($urandom), $urandom_range(0, shadow.count));
            else
              send(REQ_DELETE, 8'($urandom), $urandom_range(0, shadow.count - 1));
          end
          repeat (HIST + 2) send(REQ_UNDO, 8'($urandom), $urandom_range(0, 127));
          repeat (HIST + 2) send(REQ_REDO, 8'($urandom), $urandom_range(0, 127));
        end
        8: begin
          n = $urandom_range(1, 6);
          repeat (n) send(3'($urandom), 8'($urandom), $urandom_range(0, 127));
        end
        default: begin
          quiet();
          n = $urandom_range(1, 10);
          repeat (n) random_request();
        end
      endcase
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    directed();
    quiet();
    random_phase();
    quiet();
    repeat (SETTLE) @(posedge clk);
    if (shadow.errors == 0 && shadow.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
